[rtl/mada_pkg.sv]
// ============================================================================
// mada_pkg: shared types and constants of the deviation alarm
// Field widths, reset values, register indexes and the cell control bundle.
// ============================================================================
package mada_pkg;

    localparam int MAG_W          = 16;
    localparam int THR_W          = 19;
    localparam int DEV_W          = 19;
    localparam int WINDOW_LEN_DEF = 8;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [THR_W-1:0]     THR_RESET           = THR_W'(800);
    localparam logic [REG_IDX_W-1:0] REG_ALERT_THRESHOLD = REG_IDX_W'(0);

    // Control that the top level broadcasts to every cell of the sample line.
    typedef struct packed {
        logic load_all;  // first item after reset: every cell takes the sample
        logic shift;     // item accepted: every cell takes its neighbor's value
    } t_cell_ctrl;

endpackage

[rtl/moving_average_deviation_alarm.sv]
// ============================================================================
// moving_average_deviation_alarm: moving-average deviation alarm
// Compares each magnitude sample with the mean of the previous window of
// samples and emits an alert item carrying the deviation when it exceeds a
// programmable threshold.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  ------------------------------
//  sample    in         i_valid / o_ready    i_magnitude   [15:0] unsigned
//  alert     out        o_valid / i_ready    o_deviation   [18:0] unsigned
//  config    in (APB)   psel/penable/pready  alert_threshold at address 0
//
//  One sample item is accepted per cycle while o_ready is high. An alert item
//  passes the compare stage register, then the reciprocal multiplier that
//  divides by the window length and the output register behind it.
//  Synchronous active-low reset clears the fill count, the running sum, the
//  pipeline valid bits and loads the threshold with 800; the sample cells
//  are not reset, since the first sample overwrites all of them.
//  A stalled alert item waits in the output register, and a second alert
//  waits behind it in the compare stage. While both are held and i_ready is
//  low, o_ready is low and every sample waits, even one that raises no alert.
//
module moving_average_deviation_alarm
    import mada_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [MAG_W-1:0]      i_magnitude,

    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DEV_W-1:0]      o_deviation,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LOG_N = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = MAG_W + LOG_N;
    localparam int X_W   = SUM_W + 3;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW_LEN);

    // ------------------------------------------------------------------
    // Configuration register. Writes complete in the APB access phase.
    // ------------------------------------------------------------------
    logic [THR_W-1:0]     r_threshold;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_write;

    assign w_reg_idx   = paddr[APB_ADDR_W-1:2];
    assign w_cfg_write = psel && penable && pwrite;
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (w_cfg_write && (w_reg_idx == REG_ALERT_THRESHOLD)) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        if (w_reg_idx == REG_ALERT_THRESHOLD) begin
            prdata = {{(APB_DATA_W - THR_W){1'b0}}, r_threshold};
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Sample line. Cell 0 holds the newest sample and the last cell the
    // oldest one, which leaves the window when the next item is accepted.
    // ------------------------------------------------------------------
    logic             w_accept;
    logic             w_s1_ready;
    t_cell_ctrl       w_ctrl;
    logic [MAG_W-1:0] w_cell_q [WINDOW_LEN];
    logic [CNT_W-1:0] r_fill;
    logic             w_empty;
    logic             w_full;

    assign o_ready  = w_s1_ready;
    assign w_accept = i_valid && w_s1_ready;
    assign w_empty  = (r_fill == '0);
    assign w_full   = (r_fill == FULL_CNT);

    assign w_ctrl.load_all = w_accept && w_empty;
    assign w_ctrl.shift    = w_accept;

    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
        logic [MAG_W-1:0] w_prev;
        if (g == 0) begin : g_head
            assign w_prev = i_magnitude;
        end else begin : g_body
            assign w_prev = w_cell_q[g-1];
        end
        mada_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample (i_magnitude),
            .i_prev   (w_prev),
            .o_sample (w_cell_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Running sum and fill count. The first item fills the whole window,
    // so the sum becomes N times that sample.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] w_nsample;

    assign w_nsample = SUM_W'(i_magnitude) * SUM_W'(WINDOW_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (w_accept) begin
            if (w_empty) begin
                r_sum <= w_nsample;
            end else begin
                r_sum <= r_sum - SUM_W'(w_cell_q[WINDOW_LEN-1]) + SUM_W'(i_magnitude);
            end
            if (!w_full) begin
                r_fill <= r_fill + CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Compare stage. The numerator 8*|N*sample - sum| is compared exactly
    // with threshold*N; only alerts move on to the divide stage.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] w_diff;
    logic [X_W-1:0]   w_x;
    logic [X_W-1:0]   w_limit;
    logic             w_alert;
    logic             r_s1_valid;
    logic [X_W-1:0]   r_s1_x;
    logic             w_scale_ready;

    assign w_diff  = (w_nsample >= r_sum) ? (w_nsample - r_sum) : (r_sum - w_nsample);
    assign w_x     = {w_diff, 3'b000};
    assign w_limit = X_W'(r_threshold) * X_W'(WINDOW_LEN);
    assign w_alert = w_full && (w_x > w_limit);

    assign w_s1_ready = !r_s1_valid || w_scale_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_accept && w_alert;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_ready) begin
            r_s1_x <= w_x;
        end
    end

    // ------------------------------------------------------------------
    // Divide by the window length and hold the alert item for the output.
    // ------------------------------------------------------------------
    mada_scale #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .o_ready     (w_scale_ready),
        .i_x         (r_s1_x),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_deviation (o_deviation)
    );

endmodule

[rtl/mada_cell.sv]
// ============================================================================
// mada_cell: one sample cell of the window line
// Holds one past sample and passes it to the next cell on every accepted item.
// ============================================================================
module mada_cell
    import mada_pkg::*;
(
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [MAG_W-1:0] i_sample,
    input  logic [MAG_W-1:0] i_prev,
    output logic [MAG_W-1:0] o_sample
);

    logic [MAG_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_all) begin
            r_sample <= i_sample;
        end else if (i_ctrl.shift) begin
            r_sample <= i_prev;
        end
    end

    assign o_sample = r_sample;

endmodule

[rtl/mada_scale.sv]
// ============================================================================
// mada_scale: divide the deviation numerator by the window length
// Multiplies by a rounded-up reciprocal and holds the result in the output
// register of the result channel.
// ============================================================================
module mada_scale
    import mada_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [MAG_W+$clog2(WINDOW_LEN)+2:0]    i_x,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [DEV_W-1:0]                       o_deviation
);

    localparam int LOG_N = $clog2(WINDOW_LEN);
    localparam int X_W   = MAG_W + LOG_N + 3;
    // With K = X_W + ceil(log2 N) and M = ceil(2^K / N), floor(x*M / 2^K)
    // equals floor(x / N) for every x below 2^X_W.
    localparam int K     = X_W + LOG_N;
    localparam int P_W   = X_W + K;
    localparam longint unsigned RECIP_L =
        ((longint'(1) << K) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN);
    localparam logic [K-1:0] RECIP = K'(RECIP_L);

    logic             r_valid;
    logic [DEV_W-1:0] r_dev;
    logic [P_W-1:0]   w_prod;

    assign w_prod  = {{K{1'b0}}, i_x} * {{X_W{1'b0}}, RECIP};
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dev <= w_prod[K +: DEV_W];
        end
    end

    assign o_valid     = r_valid;
    assign o_deviation = r_dev;

endmodule
